[rtl/tlvd_pkg.sv]
// Package for the TLV field deframer: phase and result-kind codes, and the
// structs that pass parser state and results between modules. No dependencies.
package tlvd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned KIND_W = 2;

   typedef enum logic [1:0] {
      PH_DESC = 2'd0,
      PH_LEN1 = 2'd1,
      PH_LEN2 = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      phase_type          phase;
      logic [BYTE_W-1:0]  held_descriptor;
      logic [BYTE_W-1:0]  first_length_byte;
      logic [LEN_W-1:0]   held_length;
      logic [LEN_W-1:0]   bytes_remaining;
   } parse_state_type;

   typedef struct packed {
      kind_type           kind;
      logic [BYTE_W-1:0]  field_descriptor;
      logic [LEN_W-1:0]   field_length;
      logic [BYTE_W-1:0]  data_value;
      logic               field_end;
      logic               payload_end;
   } result_type;

endpackage

[rtl/tlvd_if.sv]
// Valid/ready word channels of the TLV field deframer: payload bytes in,
// tagged results out. Depends on tlvd_pkg for field widths.
interface tlvd_req_if;
   logic                         valid;
   logic                         ready;
   logic [tlvd_pkg::BYTE_W-1:0]  byte_value;
   logic                         payload_last;

   modport source (output valid, output byte_value, output payload_last, input ready);
   modport sink   (input valid, input byte_value, input payload_last, output ready);
endinterface

interface tlvd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tlvd_pkg::KIND_W-1:0]  kind;
   logic [tlvd_pkg::BYTE_W-1:0]  field_descriptor;
   logic [tlvd_pkg::LEN_W-1:0]   field_length;
   logic [tlvd_pkg::BYTE_W-1:0]  data_value;
   logic                         field_end;
   logic                         payload_end;

   modport source (output valid, output kind, output field_descriptor, output field_length,
                   output data_value, output field_end, output payload_end, input ready);
   modport sink   (input valid, input kind, input field_descriptor, input field_length,
                   input data_value, input field_end, input payload_end, output ready);
endinterface

[rtl/tlv_field_deframer.sv]
// Top level of the TLV field deframer: parser state, result register and
// the byte-order register. Depends on tlvd_pkg, tlvd_if and tlvd_parse.

// The deframer takes one payload byte per word on req_bus, with payload_last
// on the final byte, and splits the payload into fields of a descriptor byte,
// a two-byte length and that many data bytes. Every data byte leaves on
// rsp_bus tagged with its field's descriptor and length; a zero-length field
// gives one empty-field word; a payload that ends inside a header or inside
// data gives one truncation error word, after which the consumer should drop
// whatever it already took from that payload. Header bytes give no word.
// Rate: one byte per clock while no result sits unread. Each byte updates the phase and
// counter registers in the cycle it is accepted, and its result is loaded into a
// single output register in that same cycle. The byte is taken whenever that
// register is empty or is being drained in the same cycle, so req_bus only
// stalls while a result sits unread. csr_write_data selects the length byte
// order (0 low byte first, 1 high byte first); write it only while idle.
module tlv_field_deframer (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic            csr_write_data,
   tlvd_req_if.sink        req_bus,
   tlvd_rsp_if.source      rsp_bus
);
   import tlvd_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   logic            length_high_first_ff;
   logic            rsp_valid_ff;
   result_type      rsp_data_ff;

   logic            req_accept;
   logic            res_valid;
   result_type      res;

   // Take a byte when the result register is free or emptying now.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   tlvd_parse u_parse (
      .cur_state         (state_ff),
      .byte_value        (req_bus.byte_value),
      .payload_last      (req_bus.payload_last),
      .length_high_first (length_high_first_ff),
      .nxt_state         (state_in),
      .res_valid         (res_valid),
      .res               (res)
   );

   // Byte-order register.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_high_first_ff <= 1'b0;
      end else if (csr_write_enable) begin
         length_high_first_ff <= csr_write_data;
      end
   end

   // Advance parser state on each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase             <= PH_DESC;
         state_ff.held_descriptor   <= '0;
         state_ff.first_length_byte <= '0;
         state_ff.held_length       <= '0;
         state_ff.bytes_remaining   <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Result register: drop the word once taken, load a new one on accept.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_accept && res_valid) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // Hold the payload until the next result replaces it.
   always_ff @(posedge clock) begin
      if (req_accept && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.kind             = rsp_data_ff.kind;
   assign rsp_bus.field_descriptor = rsp_data_ff.field_descriptor;
   assign rsp_bus.field_length     = rsp_data_ff.field_length;
   assign rsp_bus.data_value       = rsp_data_ff.data_value;
   assign rsp_bus.field_end        = rsp_data_ff.field_end;
   assign rsp_bus.payload_end      = rsp_data_ff.payload_end;

endmodule

[rtl/tlvd_parse.sv]
// Next-state and result logic of the deframer for one payload byte.
// Depends on tlvd_pkg for the state and result structs.
module tlvd_parse (
   input  tlvd_pkg::parse_state_type   cur_state,
   input  logic [tlvd_pkg::BYTE_W-1:0] byte_value,
   input  logic                        payload_last,
   input  logic                        length_high_first,
   output tlvd_pkg::parse_state_type   nxt_state,
   output logic                        res_valid,
   output tlvd_pkg::result_type        res
);
   import tlvd_pkg::*;

   logic [LEN_W-1:0] len_decoded;
   logic [LEN_W-1:0] rem;
   logic             data_fend;

   // Assemble the length from the held first byte and this byte.
   assign len_decoded = length_high_first ? {cur_state.first_length_byte, byte_value}
                                          : {byte_value, cur_state.first_length_byte};
   assign rem       = cur_state.bytes_remaining - LEN_W'(1);
   assign data_fend = (rem == '0);

   always_comb begin
      nxt_state = cur_state;
      unique case (cur_state.phase)
         PH_DESC: begin
            nxt_state.held_descriptor = byte_value;
            nxt_state.phase = payload_last ? PH_DESC : PH_LEN1;
         end
         PH_LEN1: begin
            nxt_state.first_length_byte = byte_value;
            nxt_state.phase = payload_last ? PH_DESC : PH_LEN2;
         end
         PH_LEN2: begin
            nxt_state.held_length = len_decoded;
            if ((len_decoded == '0) || payload_last) begin
               nxt_state.phase = PH_DESC;
            end else begin
               nxt_state.bytes_remaining = len_decoded;
               nxt_state.phase = PH_DATA;
            end
         end
         PH_DATA: begin
            nxt_state.bytes_remaining = rem;
            if (data_fend || payload_last) begin
               nxt_state.phase = PH_DESC;
            end
         end
         default: nxt_state.phase = PH_DESC;
      endcase
   end

   always_comb begin
      res_valid            = 1'b0;
      res.kind             = KIND_ERROR;
      res.field_descriptor = cur_state.held_descriptor;
      res.field_length     = '0;
      res.data_value       = '0;
      res.field_end        = 1'b1;
      res.payload_end      = 1'b1;
      unique case (cur_state.phase)
         PH_DESC: begin
            // Payload ends on a bare descriptor: report it with the byte itself.
            res_valid            = payload_last;
            res.field_descriptor = byte_value;
         end
         PH_LEN1: begin
            res_valid = payload_last;
         end
         PH_LEN2: begin
            res.field_length = len_decoded;
            if (len_decoded == '0) begin
               res_valid       = 1'b1;
               res.kind        = KIND_EMPTY;
               res.payload_end = payload_last;
            end else begin
               res_valid = payload_last;
            end
         end
         PH_DATA: begin
            res_valid        = 1'b1;
            res.field_length = cur_state.held_length;
            if (!data_fend && payload_last) begin
               res.kind = KIND_ERROR;
            end else begin
               res.kind        = KIND_DATA;
               res.data_value  = byte_value;
               res.field_end   = data_fend;
               res.payload_end = data_fend && payload_last;
            end
         end
         default: res_valid = 1'b0;
      endcase
   end

endmodule

[tb/tb_tlv_field_deframer.sv]
// Testbench for tlv_field_deframer: feeds payload bytes over the request channel
// with random gaps and stalls, and checks every result word against a parser of its own.
// Depends on tlvd_pkg, the tlvd_req_if/tlvd_rsp_if interfaces and the deframer RTL.
module tb_tlv_field_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import tlvd_pkg::*;

   // One word of the request channel: a payload byte and its end-of-payload flag.
   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              payload_last;
   } byte_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic csr_write_data;

   tlvd_req_if req_bus ();
   tlvd_rsp_if rsp_bus ();

   tlv_field_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   always #10 clock = ~clock;

   // Parser state, mirrored from the block's reset values; reset is applied once.
   phase_type         pf_phase      = PH_DESC;
   logic [BYTE_W-1:0] pf_descriptor = '0;
   logic [BYTE_W-1:0] pf_first_len  = '0;
   logic [LEN_W-1:0]  pf_length     = '0;
   logic [LEN_W-1:0]  pf_remaining  = '0;
   logic              pf_high_first = 1'b0;

   byte_word_type pending_bytes[$];     // bytes waiting to be offered to the block
   byte_word_type payload_buf[$];       // payload under construction
   result_type    expected_results[$];  // results predicted but not yet seen

   bit byte_taken     = 1'b0;  // set at the edge that accepts a byte, cleared by the driver
   bit gaps_on        = 1'b1;  // allow idle bursts on both channels
   int req_gap        = 0;
   int rsp_gap        = 0;
   int mismatch_count = 0;
   int results_seen   = 0;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      // Cap the log; a badly broken block would otherwise flood it.
      if (mismatch_count <= 100)
         $display("%0t ns: %s", $time, msg);
   endtask

   // Append one word to the bytes waiting for the driver.
   task automatic add_pending(input byte_word_type w);
      pending_bytes = {pending_bytes, w};
   endtask

   // Append one word to the payload under construction.
   task automatic add_payload(input byte_word_type w);
      payload_buf = {payload_buf, w};
   endtask

   function automatic result_type make_result(input kind_type k, input logic [BYTE_W-1:0] d,
                                              input logic [LEN_W-1:0] l,
                                              input logic [BYTE_W-1:0] v,
                                              input logic fe, input logic pe);
      result_type r;
      r.kind             = k;
      r.field_descriptor = d;
      r.field_length     = l;
      r.data_value       = v;
      r.field_end        = fe;
      r.payload_end      = pe;
      return r;
   endfunction

   // Advance the parser by one accepted byte. Return 1 when the byte yields a
   // result word, which is left in r.
   function automatic bit parse_byte(input logic [BYTE_W-1:0] b, input logic last,
                                     output result_type r);
      logic [LEN_W-1:0] rem;
      r = make_result(KIND_DATA, '0, '0, '0, 1'b0, 1'b0);
      parse_byte = 1'b1;
      case (pf_phase)
         PH_DESC: begin
            pf_descriptor = b;
            // A payload that ends on its descriptor reports that descriptor.
            if (last)
               r = make_result(KIND_ERROR, b, '0, '0, 1'b1, 1'b1);
            else begin
               pf_phase   = PH_LEN1;
               parse_byte = 1'b0;
            end
         end
         PH_LEN1: begin
            pf_first_len = b;
            if (last) begin
               r        = make_result(KIND_ERROR, pf_descriptor, '0, '0, 1'b1, 1'b1);
               pf_phase = PH_DESC;
            end else begin
               pf_phase   = PH_LEN2;
               parse_byte = 1'b0;
            end
         end
         PH_LEN2: begin
            pf_length = pf_high_first ? {pf_first_len, b} : {b, pf_first_len};
            if (pf_length == '0) begin
               // Empty field: closes the payload only if this byte is flagged.
               r        = make_result(KIND_EMPTY, pf_descriptor, '0, '0, 1'b1, last);
               pf_phase = PH_DESC;
            end else if (last) begin
               // Length decoded but no room left for its data.
               r        = make_result(KIND_ERROR, pf_descriptor, pf_length, '0, 1'b1, 1'b1);
               pf_phase = PH_DESC;
            end else begin
               pf_remaining = pf_length;
               pf_phase     = PH_DATA;
               parse_byte   = 1'b0;
            end
         end
         default: begin
            rem          = pf_remaining - 1'b1;
            pf_remaining = rem;
            if (rem != '0 && last) begin
               // Payload cut inside the data: the byte is replaced by the error.
               r        = make_result(KIND_ERROR, pf_descriptor, pf_length, '0, 1'b1, 1'b1);
               pf_phase = PH_DESC;
            end else begin
               r = make_result(KIND_DATA, pf_descriptor, pf_length, b, rem == '0,
                               rem == '0 && last);
               if (rem == '0)
                  pf_phase = PH_DESC;
            end
         end
      endcase
   endfunction

   // Driver: present the oldest pending byte at the falling edge and hold it
   // until accepted. Open an idle burst only between words, never mid-word.
   always @(negedge clock) begin : drive_bytes
      bit took;
      took       = byte_taken;
      byte_taken = 1'b0;
      if (took)
         void'(pending_bytes.pop_front());
      if (!reset && !(req_bus.valid && !took)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 8);
            req_bus.valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_bus.valid        <= 1'b1;
            req_bus.byte_value   <= pending_bytes[0].byte_value;
            req_bus.payload_last <= pending_bytes[0].payload_last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result sink: stall in random bursts, otherwise keep ready high.
   always @(negedge clock) begin : drive_ready
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 8);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Monitor: at the rising edge check a delivered result word first, then
   // predict from an accepted byte, so a fresh prediction never covers a stray word.
   always @(posedge clock) begin : watch_words
      result_type want;
      result_type fresh;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none expected (kind %0d)",
                                         results_seen, rsp_bus.kind));
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.kind !== want.kind)
                  report_mismatch($sformatf("result %0d kind: got %0d, want %0d",
                                            results_seen, rsp_bus.kind, want.kind));
               if (rsp_bus.field_descriptor !== want.field_descriptor)
                  report_mismatch($sformatf("result %0d descriptor: got %0h, want %0h",
                                            results_seen, rsp_bus.field_descriptor,
                                            want.field_descriptor));
               if (rsp_bus.field_length !== want.field_length)
                  report_mismatch($sformatf("result %0d length: got %0d, want %0d",
                                            results_seen, rsp_bus.field_length,
                                            want.field_length));
               if (rsp_bus.data_value !== want.data_value)
                  report_mismatch($sformatf("result %0d data: got %0h, want %0h",
                                            results_seen, rsp_bus.data_value, want.data_value));
               if (rsp_bus.field_end !== want.field_end)
                  report_mismatch($sformatf("result %0d field_end: got %b, want %b",
                                            results_seen, rsp_bus.field_end, want.field_end));
               if (rsp_bus.payload_end !== want.payload_end)
                  report_mismatch($sformatf("result %0d payload_end: got %b, want %b",
                                            results_seen, rsp_bus.payload_end,
                                            want.payload_end));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            byte_taken = 1'b1;
            if (parse_byte(req_bus.byte_value, req_bus.payload_last, fresh))
               expected_results = {expected_results, fresh};
         end
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] v, input logic last);
      add_pending({v, last});
   endtask

   // Append a field header plus data_count random data bytes to the payload
   // under construction; the length goes out in the current byte order.
   task automatic add_field(input logic [LEN_W-1:0] len, input int unsigned data_count);
      add_payload({8'($urandom), 1'b0});
      if (pf_high_first) begin
         add_payload({len[15:8], 1'b0});
         add_payload({len[7:0], 1'b0});
      end else begin
         add_payload({len[7:0], 1'b0});
         add_payload({len[15:8], 1'b0});
      end
      repeat (data_count)
         add_payload({8'($urandom), 1'b0});
   endtask

   function automatic int unsigned pick_length();
      if ($urandom_range(0, 3) == 0)
         return 0;
      if ($urandom_range(0, 4) == 0)
         return $urandom_range(5, 12);
      return $urandom_range(1, 4);
   endfunction

   // Build one payload and queue it. Most are well formed; some are cut short
   // in a header or in the data of a field (often with a huge length); a few
   // are raw noise with the end flag scattered at random.
   task automatic queue_payload();
      int unsigned shape;
      int unsigned nfields;
      int unsigned len;
      int unsigned count;
      shape = $urandom_range(0, 9);
      payload_buf.delete();
      if (shape == 9) begin
         count = $urandom_range(1, 8);
         repeat (count)
            add_payload({8'($urandom), $urandom_range(0, 3) == 0});
      end else begin
         nfields = (shape >= 6) ? $urandom_range(0, 2) : $urandom_range(1, 3);
         repeat (nfields) begin
            len = pick_length();
            add_field(LEN_W'(len), len);
         end
         if (shape >= 6) begin
            if ($urandom_range(0, 3) == 0) begin
               // Cut inside the header: descriptor alone or with one length byte.
               add_payload({8'($urandom), 1'b0});
               if ($urandom_range(0, 1) == 1)
                  add_payload({8'($urandom), 1'b0});
            end else begin
               len = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 65535)
                                                 : $urandom_range(2, 8);
               add_field(LEN_W'(len), $urandom_range(0, (len > 7) ? 6 : len - 1));
            end
         end
      end
      payload_buf[payload_buf.size() - 1].payload_last = 1'b1;
      foreach (payload_buf[i])
         add_pending(payload_buf[i]);
   endtask

   // Write the byte-order register; only called while the block is idle.
   task automatic set_byte_order(input logic high_first);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= high_first;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      pf_high_first = high_first;
   endtask

   // Wait until every byte is taken and every predicted word has arrived,
   // then idle on before the next phase, since a header byte yields no word.
   task automatic drain();
      while (pending_bytes.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin : run_test
      req_bus.valid        = 1'b0;
      req_bus.byte_value   = '0;
      req_bus.payload_last = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_write_enable     = 1'b0;
      csr_write_data       = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed payloads, low byte of the length first.
      set_byte_order(1'b0);
      push_byte(8'hFF, 1'b1);                        // ends on its descriptor
      push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1); // ends on first length byte
      push_byte(8'hA5, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1); // empty, closes
      push_byte(8'h5A, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); // empty, open
      push_byte(8'h01, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);                        // one data byte closes the payload
      push_byte(8'h7E, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h00, 1'b1); // no room for data
      push_byte(8'h33, 1'b0); push_byte(8'h03, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b1); // cut inside the data
      push_byte(8'hC3, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);                        // largest length, cut short
      drain();

      // Random phases, alternating byte order. Run one middle phase and the
      // last phase with no idling at all.
      for (int p = 0; p < 5; p++) begin
         set_byte_order(p % 2 == 0);
         gaps_on = (p != 2) && (p != 4);
         while (pending_bytes.size() < 120)
            queue_payload();
         drain();
      end

      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this.
   initial begin : watchdog
      #(2_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
rtl/tlvd_pkg.sv
rtl/tlvd_if.sv
rtl/tlvd_parse.sv
rtl/tlv_field_deframer.sv
tb/tb_tlv_field_deframer.sv
